// File: design/swgi_pkg.sv
// Shared types and constants for the short-window group interleave core.
// Holds the position record, the decoded configuration record and register codes.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package swgi_pkg;

   // Limits of the address generator.
   localparam int MaxBands   = 15;
   localparam int MaxGroups  = 8;
   localparam int MaxFrame   = 1024;

   // Field widths fixed by the register and stream formats.
   localparam int AddrW      = $clog2(MaxFrame);
   localparam int CoefW      = 32;
   localparam int SwlW       = 8;
   localparam int CntW       = 4;
   localparam int GlenW      = 4;
   localparam int BwW        = 6;
   localparam int LineW      = 6;
   localparam int WinW       = 4;
   localparam int BandW      = 4;
   localparam int GroupW     = 3;
   localparam int ProdW      = SwlW + GlenW;
   localparam int BandSlots  = 16;
   localparam int GroupSlots = 8;
   localparam int BwLowSlots = 8;
   localparam int BwHighW    = 42;
   localparam int GlensW     = GroupSlots * GlenW;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 48;

   typedef logic [AddrW-1:0]      addr_type;
   typedef logic [CntW-1:0]       cnt_type;
   typedef logic [ProdW-1:0]      prod_type;
   typedef logic [BandW-1:0]      band_type;
   typedef logic [GroupW-1:0]     group_type;
   typedef logic [BandSlots-1:0]  bmask_type;
   typedef logic [GroupSlots-1:0] gmask_type;

   // Saturation limits for the group and band counts.
   localparam cnt_type EffGroupsMax = cnt_type'(MaxGroups);
   localparam cnt_type EffBandsMax  = cnt_type'(MaxBands);

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_SHORT_WINDOW_LEN = 3'd0,
      CSR_NUM_GROUPS       = 3'd1,
      CSR_GROUP_LENGTHS    = 3'd2,
      CSR_NUM_BANDS        = 3'd3,
      CSR_BAND_WIDTHS_LOW  = 3'd4,
      CSR_BAND_WIDTHS_HIGH = 3'd5
   } csr_addr_type;

   // Position inside the frame: counters and the three address bases.
   typedef struct packed {
      logic [LineW-1:0]  line;
      logic [WinW-1:0]   win;
      logic [BandW-1:0]  band;
      logic [GroupW-1:0] group;
      logic [AddrW-1:0]  bstart;
      logic [AddrW-1:0]  gbase;
      logic [AddrW-1:0]  wbase;
   } state_type;

   // Decoded configuration, registered once per cycle from the raw registers.
   typedef struct packed {
      logic [SwlW-1:0]                   swl;
      logic [CntW-1:0]                   eff_groups;
      logic [CntW-1:0]                   eff_bands;
      logic [GroupSlots-1:0][GlenW-1:0]  glen;
      logic [BandSlots-1:0][BwW-1:0]     bw;
      logic [GroupSlots-1:0][AddrW-1:0]  gprod;
      logic [BandSlots-1:0]              bmask;
      logic [GroupSlots-1:0]             gmask;
   } cfg_type;

endpackage

`default_nettype wire

// File: design/short_window_group_interleave_core.sv
// Top level of the short-window group interleave address generator.
// Instantiates swgi_csr, swgi_walker and swgi_advance; uses swgi_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_coeff_value
//   rsp      out        rsp_valid / rsp_ready  rsp_natural_index, rsp_coeff_out,
//                                              rsp_last_of_frame
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One coefficient per cycle while the position is settled and rsp is not stalled:
// input register, index and position logic, result register; a req transfer loads
// the input register and s1_go loads the result register behind rsp_valid. After
// reset or a register write, the walker steps the frame position one step a cycle
// (one step per window of each band, at most two frame passes) before the next
// coefficient moves on. Reset is synchronous; csr_ready is always high. A stalled
// rsp holds its result while one more coefficient waits in the input register.
`default_nettype none

module short_window_group_interleave_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [swgi_pkg::CoefW-1:0]     req_coeff_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [swgi_pkg::AddrW-1:0]            rsp_natural_index,
   output logic signed [swgi_pkg::CoefW-1:0]     rsp_coeff_out,
   output logic                                  rsp_last_of_frame,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swgi_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [swgi_pkg::CsrDataW-1:0]         csr_wdata
);

   swgi_pkg::cfg_type   cfg;
   swgi_pkg::state_type pos;
   swgi_pkg::state_type adv_next;
   swgi_pkg::addr_type  adv_index;
   logic                adv_last;
   logic                cfg_restart;
   logic                walk_settled;
   logic                walk_empty;

   logic                              s1_valid_ff;
   logic signed [swgi_pkg::CoefW-1:0] s1_coeff_ff;
   logic                              rsp_valid_ff;
   swgi_pkg::addr_type                rsp_index_ff;
   logic signed [swgi_pkg::CoefW-1:0] rsp_coeff_ff;
   logic                              rsp_last_ff;
   logic                              out_free;
   logic                              s1_go;

   swgi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .cfg_restart (cfg_restart)
   );

   swgi_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_restart (cfg_restart),
      .adv         (s1_go),
      .adv_next    (adv_next),
      .pos         (pos),
      .settled     (walk_settled),
      .empty       (walk_empty)
   );

   swgi_advance u_advance (
      .cfg           (cfg),
      .pos           (pos),
      .natural_index (adv_index),
      .nxt           (adv_next),
      .last          (adv_last)
   );

   // The input register moves on when the position is settled and the output has room.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && walk_settled && out_free;
   assign req_ready = !s1_valid_ff || s1_go;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= s1_go;
      end
   end

   // Payload capture on each transfer; an empty frame gives index zero and the flag.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) s1_coeff_ff <= req_coeff_value;
      if (s1_go) begin
         rsp_index_ff <= walk_empty ? '0 : adv_index;
         rsp_coeff_ff <= s1_coeff_ff;
         rsp_last_ff  <= walk_empty ? 1'b1 : adv_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_natural_index = rsp_index_ff;
   assign rsp_coeff_out     = rsp_coeff_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/swgi_csr.sv
// Configuration registers of the interleave core and their decoded form.
// Depends on swgi_pkg for the register codes and the configuration record.
`default_nettype none

module swgi_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [swgi_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [swgi_pkg::CsrDataW-1:0]   csr_wdata,
   output swgi_pkg::cfg_type               cfg,
   output logic                            cfg_restart
);

   logic [swgi_pkg::SwlW-1:0]     swl_ff;
   logic [swgi_pkg::CntW-1:0]     ngroups_ff;
   logic [swgi_pkg::GlensW-1:0]   glens_ff;
   logic [swgi_pkg::CntW-1:0]     nbands_ff;
   logic [swgi_pkg::CsrDataW-1:0] bwlo_ff;
   logic [swgi_pkg::BwHighW-1:0]  bwhi_ff;
   logic                          wr_d_ff;
   swgi_pkg::cfg_type             cfg_ff;
   swgi_pkg::cfg_type             cfg_in;
   swgi_pkg::prod_type            prod;

   // Register writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         swl_ff     <= 8'd128;
         ngroups_ff <= 4'd1;
         glens_ff   <= 32'd8;
         nbands_ff  <= 4'd1;
         bwlo_ff    <= '0;
         bwhi_ff    <= '0;
         wr_d_ff    <= 1'b1;
      end else begin
         wr_d_ff <= csr_valid;
         if (csr_valid) begin
            unique case (csr_index)
               swgi_pkg::CSR_SHORT_WINDOW_LEN: swl_ff     <= csr_wdata[swgi_pkg::SwlW-1:0];
               swgi_pkg::CSR_NUM_GROUPS:       ngroups_ff <= csr_wdata[swgi_pkg::CntW-1:0];
               swgi_pkg::CSR_GROUP_LENGTHS:    glens_ff   <= csr_wdata[swgi_pkg::GlensW-1:0];
               swgi_pkg::CSR_NUM_BANDS:        nbands_ff  <= csr_wdata[swgi_pkg::CntW-1:0];
               swgi_pkg::CSR_BAND_WIDTHS_LOW:  bwlo_ff    <= csr_wdata;
               swgi_pkg::CSR_BAND_WIDTHS_HIGH: bwhi_ff    <= csr_wdata[swgi_pkg::BwHighW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Decode: saturated counts, per-slot widths and lengths, group spans, nonempty masks.
   always_comb begin
      prod              = '0;
      cfg_in            = '0;
      cfg_in.swl        = swl_ff;
      cfg_in.eff_groups = (ngroups_ff > swgi_pkg::EffGroupsMax) ?
                          swgi_pkg::EffGroupsMax : ngroups_ff;
      cfg_in.eff_bands  = (nbands_ff > swgi_pkg::EffBandsMax) ?
                          swgi_pkg::EffBandsMax : nbands_ff;
      for (int g = 0; g < swgi_pkg::GroupSlots; g++) begin
         cfg_in.glen[g]  = glens_ff[g*swgi_pkg::GlenW +: swgi_pkg::GlenW];
         prod            = swgi_pkg::prod_type'(swl_ff) * swgi_pkg::prod_type'(cfg_in.glen[g]);
         cfg_in.gprod[g] = prod[swgi_pkg::AddrW-1:0];
         cfg_in.gmask[g] = (swgi_pkg::cnt_type'(g) < cfg_in.eff_groups) &&
                           (cfg_in.glen[g] != '0);
      end
      for (int b = 0; b < swgi_pkg::BandSlots; b++) begin
         if (b < swgi_pkg::BwLowSlots) begin
            cfg_in.bw[b] = bwlo_ff[b*swgi_pkg::BwW +: swgi_pkg::BwW];
         end else if (b < swgi_pkg::BandSlots - 1) begin
            cfg_in.bw[b] = bwhi_ff[(b-swgi_pkg::BwLowSlots)*swgi_pkg::BwW +: swgi_pkg::BwW];
         end else begin
            cfg_in.bw[b] = '0;
         end
         cfg_in.bmask[b] = (swgi_pkg::cnt_type'(b) < cfg_in.eff_bands) && (cfg_in.bw[b] != '0);
      end
   end

   // The decoded record is a registered copy of the decode of the raw registers.
   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg         = cfg_ff;
   assign cfg_restart = csr_valid | wr_d_ff;

endmodule

`default_nettype wire

// File: design/swgi_advance.sv
// Combinational position advance for a settled frame position.
// Forms the interleaved index and the next valid position; depends on swgi_pkg.
`default_nettype none

module swgi_advance (
   input  swgi_pkg::cfg_type    cfg,
   input  swgi_pkg::state_type  pos,
   output swgi_pkg::addr_type   natural_index,
   output swgi_pkg::state_type  nxt,
   output logic                 last
);

   // Lowest set bit of a band mask, with a found flag on top.
   function automatic logic [swgi_pkg::BandW:0] first_band(input swgi_pkg::bmask_type m);
      logic [swgi_pkg::BandW:0] r;
      r = '0;
      for (int i = swgi_pkg::BandSlots - 1; i >= 0; i--) begin
         if (m[i]) r = {1'b1, swgi_pkg::band_type'(i)};
      end
      return r;
   endfunction

   // Lowest set bit of a group mask, with a found flag on top.
   function automatic logic [swgi_pkg::GroupW:0] first_group(input swgi_pkg::gmask_type m);
      logic [swgi_pkg::GroupW:0] r;
      r = '0;
      for (int i = swgi_pkg::GroupSlots - 1; i >= 0; i--) begin
         if (m[i]) r = {1'b1, swgi_pkg::group_type'(i)};
      end
      return r;
   endfunction

   logic [swgi_pkg::LineW:0]  line_up;
   logic [swgi_pkg::WinW:0]   win_up;
   swgi_pkg::bmask_type       band_above;
   swgi_pkg::gmask_type       group_above;
   logic [swgi_pkg::BandW:0]  band_hit;
   logic [swgi_pkg::BandW:0]  band_first;
   logic [swgi_pkg::GroupW:0] group_hit;
   logic [swgi_pkg::GroupW:0] group_first;

   // Interleaved position of the current coefficient.
   assign natural_index = pos.bstart + pos.wbase + pos.gbase + swgi_pkg::addr_type'(pos.line);

   // Nonempty bands and groups after the current ones.
   always_comb begin
      band_above  = cfg.bmask & ~((swgi_pkg::bmask_type'(2) << pos.band) -
                                  swgi_pkg::bmask_type'(1));
      group_above = cfg.gmask & ~((swgi_pkg::gmask_type'(2) << pos.group) -
                                  swgi_pkg::gmask_type'(1));
      band_hit    = first_band(band_above);
      band_first  = first_band(cfg.bmask);
      group_hit   = first_group(group_above);
      group_first = first_group(cfg.gmask);
   end

   // Next line, next window, next band, next group, or back to the frame start.
   always_comb begin
      nxt     = pos;
      last    = 1'b0;
      line_up = {1'b0, pos.line} + 1'b1;
      win_up  = {1'b0, pos.win} + 1'b1;
      priority if (line_up < {1'b0, cfg.bw[pos.band]}) begin
         nxt.line = line_up[swgi_pkg::LineW-1:0];
      end else if (win_up < {1'b0, cfg.glen[pos.group]}) begin
         nxt.line  = '0;
         nxt.win   = win_up[swgi_pkg::WinW-1:0];
         nxt.wbase = pos.wbase + swgi_pkg::addr_type'(cfg.swl);
      end else begin
         nxt.line  = '0;
         nxt.win   = '0;
         nxt.wbase = '0;
         if (band_hit[swgi_pkg::BandW]) begin
            nxt.band   = band_hit[swgi_pkg::BandW-1:0];
            nxt.bstart = pos.bstart + swgi_pkg::addr_type'(cfg.bw[pos.band]);
         end else begin
            nxt.band   = band_first[swgi_pkg::BandW-1:0];
            nxt.bstart = '0;
            if (group_hit[swgi_pkg::GroupW]) begin
               nxt.group = group_hit[swgi_pkg::GroupW-1:0];
               nxt.gbase = pos.gbase + cfg.gprod[pos.group];
            end else begin
               // Frame end: the first nonempty group starts at offset zero.
               nxt.group = group_first[swgi_pkg::GroupW-1:0];
               nxt.gbase = '0;
               last      = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: design/swgi_walker.sv
// Frame position keeper: the committed position and a settled working copy.
// After a configuration change it steps the working copy one step a cycle
// until it rests on a valid coefficient or finds the frame empty. Uses swgi_pkg.
`default_nettype none

module swgi_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  swgi_pkg::cfg_type    cfg,
   input  logic                 cfg_restart,
   input  logic                 adv,
   input  swgi_pkg::state_type  adv_next,
   output swgi_pkg::state_type  pos,
   output logic                 settled,
   output logic                 empty
);

   swgi_pkg::state_type committed_ff, committed_in;
   swgi_pkg::state_type work_ff, work_in;
   swgi_pkg::state_type base;
   swgi_pkg::state_type step_next;
   logic settled_ff, settled_in;
   logic empty_ff, empty_in;
   logic wrapped_ff, wrapped_in;
   logic step_valid, step_empty, step_wrap;
   logic group_last;

   // One step of the forward search from the working position.
   always_comb begin
      step_next  = work_ff;
      step_valid = 1'b0;
      step_empty = 1'b0;
      step_wrap  = 1'b0;
      group_last = (swgi_pkg::cnt_type'(work_ff.group) + 1'b1) >= cfg.eff_groups;
      priority if (swgi_pkg::cnt_type'(work_ff.group) >= cfg.eff_groups) begin
         step_next  = '0;
         step_wrap  = 1'b1;
         step_empty = (cfg.eff_groups == '0);
      end else if ((work_ff.band >= cfg.eff_bands) ||
                   (work_ff.win >= cfg.glen[work_ff.group])) begin
         step_next.line  = '0;
         step_next.win   = '0;
         step_next.wbase = '0;
         if (({1'b0, work_ff.band} + 1'b1) >= {1'b0, cfg.eff_bands}) begin
            step_next.band   = '0;
            step_next.bstart = '0;
            if (group_last) begin
               step_next = '0;
               step_wrap = 1'b1;
            end else begin
               step_next.group = work_ff.group + 1'b1;
               step_next.gbase = work_ff.gbase + cfg.gprod[work_ff.group];
            end
         end else begin
            step_next.band   = work_ff.band + 1'b1;
            step_next.bstart = work_ff.bstart + swgi_pkg::addr_type'(cfg.bw[work_ff.band]);
         end
      end else if (work_ff.line >= cfg.bw[work_ff.band]) begin
         step_next.line  = '0;
         step_next.win   = work_ff.win + 1'b1;
         step_next.wbase = work_ff.wbase + swgi_pkg::addr_type'(cfg.swl);
      end else begin
         step_valid = 1'b1;
      end
   end

   // Commit on a transfer, restart on a register write, otherwise keep searching.
   always_comb begin
      base = committed_ff;
      if (adv) base = empty_ff ? '0 : adv_next;
      committed_in = base;
      work_in      = work_ff;
      settled_in   = settled_ff;
      empty_in     = empty_ff;
      wrapped_in   = wrapped_ff;
      priority if (cfg_restart) begin
         work_in    = base;
         settled_in = 1'b0;
         empty_in   = 1'b0;
         wrapped_in = 1'b0;
      end else if (adv) begin
         work_in = base;
      end else if (!settled_ff) begin
         priority if (step_valid) begin
            settled_in = 1'b1;
         end else if (step_empty || (step_wrap && wrapped_ff)) begin
            // No groups or a second pass without a coefficient: the frame is empty.
            work_in    = '0;
            settled_in = 1'b1;
            empty_in   = 1'b1;
         end else begin
            work_in    = step_next;
            wrapped_in = wrapped_ff | step_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         work_ff      <= '0;
         settled_ff   <= 1'b0;
         empty_ff     <= 1'b0;
         wrapped_ff   <= 1'b0;
      end else begin
         committed_ff <= committed_in;
         work_ff      <= work_in;
         settled_ff   <= settled_in;
         empty_ff     <= empty_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   assign pos     = work_ff;
   assign settled = settled_ff;
   assign empty   = empty_ff;

   // A settled, nonempty position always names an existing coefficient.
   a_settled_valid: assert property (@(posedge clock) disable iff (reset)
      (settled_ff && !empty_ff) |->
         ((swgi_pkg::cnt_type'(work_ff.group) < cfg.eff_groups) &&
          (work_ff.band < cfg.eff_bands) &&
          (work_ff.win < cfg.glen[work_ff.group]) &&
          (work_ff.line < cfg.bw[work_ff.band])))
      else $error("settled position does not name a coefficient");

   // An empty frame keeps the position at the frame start.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (settled_ff && empty_ff) |-> (work_ff == '0))
      else $error("empty frame with a nonzero position");

   // A coefficient is only consumed from a settled position.
   a_adv_settled: assert property (@(posedge clock) disable iff (reset)
      adv |-> settled_ff)
      else $error("advance while the position is still searching");

   // A register write always forces a new search.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_restart |=> !settled_ff)
      else $error("register write did not restart the search");

endmodule

`default_nettype wire
